// File: design/lpgc_pkg.sv
package lpgc_pkg;

    localparam int CELL_SIZE    = 488;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam logic [14:0] ANGLE_FULL    = 15'd23040;
    localparam logic [14:0] ANGLE_QUARTER = 15'd5760;

    // CORDIC datapath: Q30 magnitudes stay below 2^31
    localparam int CW = 33;
    // angle accumulator, degrees * 2^22
    localparam int ZW = 30;

    localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

    localparam logic signed [17:0] OUT_MAX = 18'sd131071;
    localparam logic signed [17:0] OUT_MIN = -18'sd131072;

    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_OFF_X  = 3'd2;
    localparam logic [2:0] REG_OFF_Y  = 3'd3;
    localparam logic [2:0] REG_B1_COL = 3'd4;
    localparam logic [2:0] REG_B1_ROW = 3'd5;
    localparam logic [2:0] REG_B2_COL = 3'd6;
    localparam logic [2:0] REG_B2_ROW = 3'd7;

    localparam logic [1:0] HIT_NONE   = 2'd0;
    localparam logic [1:0] HIT_FIRST  = 2'd1;
    localparam logic [1:0] HIT_SECOND = 2'd2;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(188743680);
            1:  v = ZW'(111421900);
            2:  v = ZW'(58872272);
            3:  v = ZW'(29884485);
            4:  v = ZW'(15000234);
            5:  v = ZW'(7507429);
            6:  v = ZW'(3754631);
            7:  v = ZW'(1877430);
            8:  v = ZW'(938729);
            9:  v = ZW'(469366);
            10: v = ZW'(234683);
            11: v = ZW'(117342);
            12: v = ZW'(58671);
            13: v = ZW'(29335);
            14: v = ZW'(14668);
            15: v = ZW'(7334);
            16: v = ZW'(3667);
            17: v = ZW'(1833);
            18: v = ZW'(917);
            19: v = ZW'(458);
            20: v = ZW'(229);
            21: v = ZW'(115);
            22: v = ZW'(57);
            23: v = ZW'(29);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/lpgc_cordic.sv
module lpgc_cordic
    import lpgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [14:0]          in_angle,
    input  logic [15:0]          in_range,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_cos,
    output logic signed [CW-1:0] out_sin,
    output logic [15:0]          out_range
);

    // stage 0: wrap and quadrant split
    logic        v0_reg;
    logic [12:0] r0_reg;
    logic [1:0]  q0_reg;
    logic [15:0] g0_reg;
    logic [14:0] a_w;
    logic [1:0]  q_w;
    logic [14:0] r_w;

    always_comb
    begin
        a_w = (in_angle >= ANGLE_FULL) ? (in_angle - ANGLE_FULL) : in_angle;
        if (a_w >= 15'(3 * 5760))
        begin
            q_w = 2'd3;
            r_w = a_w - 15'(3 * 5760);
        end
        else if (a_w >= 15'(2 * 5760))
        begin
            q_w = 2'd2;
            r_w = a_w - 15'(2 * 5760);
        end
        else if (a_w >= ANGLE_QUARTER)
        begin
            q_w = 2'd1;
            r_w = a_w - ANGLE_QUARTER;
        end
        else
        begin
            q_w = 2'd0;
            r_w = a_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r_w[12:0];
        q0_reg <= q_w;
        g0_reg <= in_range;
    end

    // iteration stages, one per step
    logic                 v_reg [NSTEP+1];
    logic signed [CW-1:0] x_reg [NSTEP+1];
    logic signed [CW-1:0] y_reg [NSTEP+1];
    logic signed [ZW-1:0] z_reg [NSTEP+1];
    logic [1:0]           q_reg [NSTEP+1];
    logic [15:0]          g_reg [NSTEP+1];

    always_comb
    begin
        v_reg[0] = v0_reg;
        x_reg[0] = CORDIC_X0;
        y_reg[0] = '0;
        z_reg[0] = ZW'({r0_reg, 16'd0});
        q_reg[0] = q0_reg;
        g_reg[0] = g0_reg;
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] - dy;
                y_reg[i+1] <= y_reg[i] + dx;
                z_reg[i+1] <= z_reg[i] - atan_val(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dy;
                y_reg[i+1] <= y_reg[i] - dx;
                z_reg[i+1] <= z_reg[i] + atan_val(i);
            end
            q_reg[i+1] <= q_reg[i];
            g_reg[i+1] <= g_reg[i];
        end
    end

    // quadrant rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= v_reg[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        out_range <= g_reg[NSTEP];
        case (q_reg[NSTEP])
            2'd0:
            begin
                out_cos <= x_reg[NSTEP];
                out_sin <= y_reg[NSTEP];
            end
            2'd1:
            begin
                out_cos <= -y_reg[NSTEP];
                out_sin <= x_reg[NSTEP];
            end
            2'd2:
            begin
                out_cos <= -x_reg[NSTEP];
                out_sin <= -y_reg[NSTEP];
            end
            default:
            begin
                out_cos <= y_reg[NSTEP];
                out_sin <= -x_reg[NSTEP];
            end
        endcase
    end

endmodule

// File: design/lidar_point_grid_classifier.sv
// Lidar return to field point, with a two-cell grid test.
// Input: pulse start with scan_angle (1/64 deg) and scan_range (cm Q.4);
// an item is taken at every clock edge where start is high and busy is low.
// busy is tied low: the block takes one item every cycle.
// Output: done strobes for one cycle with point_x, point_y (cm Q.4,
// saturated) and hit_block (0 none, 1 first, 2 second; first wins).
// Pipeline: the CORDIC pipeline (wrap/quadrant stage, one stage per rotation
// step, quadrant rotation) carries each item, then one multiply stage,
// sum/round, and compare/saturate, whose register raises done.
// Config: cfg_we / cfg_index / cfg_data; the user must write only while idle (not enforced).
// Reset clears all valid bits and loads the default register values.
// The receiver cannot stall; every result is shown for exactly one cycle.
module lidar_point_grid_classifier
    import lpgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [14:0]        scan_angle,
    input  logic [15:0]        scan_range,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [17:0] point_x,
    output logic signed [17:0] point_y,
    output logic [1:0]         hit_block
);

    logic [15:0]        pos_x_reg, pos_y_reg;
    logic signed [10:0] off_x_reg, off_y_reg;
    logic [7:0]         b1c_reg, b1r_reg, b2c_reg, b2r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= 16'd2195;
            pos_y_reg <= 16'd2195;
            off_x_reg <= 11'sd122;
            off_y_reg <= 11'sd56;
            b1c_reg   <= '0;
            b1r_reg   <= '0;
            b2c_reg   <= '0;
            b2r_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_X:  pos_x_reg <= cfg_data;
                REG_POS_Y:  pos_y_reg <= cfg_data;
                REG_OFF_X:  off_x_reg <= cfg_data[10:0];
                REG_OFF_Y:  off_y_reg <= cfg_data[10:0];
                REG_B1_COL: b1c_reg   <= cfg_data[7:0];
                REG_B1_ROW: b1r_reg   <= cfg_data[7:0];
                REG_B2_COL: b2c_reg   <= cfg_data[7:0];
                REG_B2_ROW: b2r_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                 cv;
    logic signed [CW-1:0] cc, cs;
    logic [15:0]          cr;

    lpgc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_angle  (scan_angle),
        .in_range  (scan_range),
        .out_valid (cv),
        .out_cos   (cc),
        .out_sin   (cs),
        .out_range (cr)
    );

    // coefficients: (ox + range) for cos/sin, oy
    logic signed [17:0] kx_w;
    assign kx_w = 18'(off_x_reg) + 18'(signed'({1'b0, cr}));

    // multiply stage: four products, 18 x 33 and 11 x 33
    logic                 m_v_reg;
    logic signed [51:0]   kc_reg, ks_reg, oc_reg, os_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else
            m_v_reg <= cv;
    end
    always_ff @(posedge clk)
    begin
        kc_reg <= 52'(kx_w * cc);
        ks_reg <= 52'(kx_w * cs);
        oc_reg <= 52'(off_y_reg * cc);
        os_reg <= 52'(off_y_reg * cs);
    end

    // sum and round
    logic               s_v_reg;
    logic signed [19:0] px_reg, py_reg;
    logic signed [51:0] sx_w, sy_w;
    assign sx_w = kc_reg - os_reg + 52'sd536870912;
    assign sy_w = ks_reg + oc_reg + 52'sd536870912;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_v_reg <= 1'b0;
        else
            s_v_reg <= m_v_reg;
    end
    always_ff @(posedge clk)
    begin
        px_reg <= 20'(sx_w >>> 30) + 20'(signed'({1'b0, pos_x_reg}));
        py_reg <= 20'(sy_w >>> 30) + 20'(signed'({1'b0, pos_y_reg}));
    end

    // cell bounds: col * CELL_SIZE and row * CELL_SIZE
    logic signed [19:0] b1x, b1y, b2x, b2y;
    assign b1x = 20'(b1c_reg * CELL_SIZE);
    assign b1y = 20'(b1r_reg * CELL_SIZE);
    assign b2x = 20'(b2c_reg * CELL_SIZE);
    assign b2y = 20'(b2r_reg * CELL_SIZE);

    logic in1, in2;
    assign in1 = px_reg >= b1x && px_reg <= b1x + 20'(CELL_SIZE)
              && py_reg >= b1y && py_reg <= b1y + 20'(CELL_SIZE);
    assign in2 = px_reg >= b2x && px_reg <= b2x + 20'(CELL_SIZE)
              && py_reg >= b2y && py_reg <= b2y + 20'(CELL_SIZE);

    function automatic logic signed [17:0] sat(input logic signed [19:0] v);
        if (v > 20'(OUT_MAX))
            return OUT_MAX;
        else if (v < 20'(OUT_MIN))
            return OUT_MIN;
        else
            return v[17:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= s_v_reg;
    end
    always_ff @(posedge clk)
    begin
        point_x   <= sat(px_reg);
        point_y   <= sat(py_reg);
        hit_block <= in1 ? HIT_FIRST : (in2 ? HIT_SECOND : HIT_NONE);
    end

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_v_reg |=> done) else $error("done lost");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !s_v_reg |=> !done) else $error("spurious done");
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hit_block <= HIT_SECOND) else $error("bad hit code");

endmodule
